>>> hdl/iee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier escape encoder package
// Shared types, character constants and the expansion of one queued job into
// its sequence of output characters.
// ----------------------------------------------------------------------------
package iee_pkg;

   localparam int CODE_W      = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int MAX_SEQ     = 9;
   localparam int SEQ_IDX_W   = $clog2(MAX_SEQ + 1);

   typedef logic [CODE_W-1:0] char_type;

   // Character codes
   localparam char_type CH_NUL     = 16'h0000;
   localparam char_type CH_ILLEGAL = 16'h0001;
   localparam char_type CH_ASCII_MAX = 16'h007F;
   localparam char_type CH_US      = 16'h005F;
   localparam char_type CH_H       = 16'h0068;
   localparam char_type CH_0       = 16'h0030;
   localparam char_type CH_1       = 16'h0031;
   localparam char_type CH_5       = 16'h0035;
   localparam char_type CH_9       = 16'h0039;
   localparam char_type CH_F_UP    = 16'h0046;
   localparam char_type CH_A_UP    = 16'h0041;
   localparam char_type CH_Z_UP    = 16'h005A;
   localparam char_type CH_A_LO    = 16'h0061;
   localparam char_type CH_Z_LO    = 16'h007A;
   localparam char_type CH_U_LO    = 16'h0075;
   localparam char_type CH_U_UP    = 16'h0055;

   // Configuration register indexes
   localparam logic REG_ENCODE_WIDE    = 1'b0;
   localparam logic REG_LOW_BYTE_FIRST = 1'b1;

   // Main body of an expansion
   typedef enum logic [2:0] {
      BODY_NONE,
      BODY_PLAIN,
      BODY_DIGIT,
      BODY_ESC_H,
      BODY_ASCII,
      BODY_WIDE_OPEN,
      BODY_WIDE_CONT
   } body_type;

   // One classified input word, waiting for expansion
   typedef struct packed {
      logic      err;
      logic      pre_us;
      body_type  body;
      logic      close_us;
      logic      lbf;
      logic      last;
      char_type  code;
   } job_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   typedef struct packed {
      logic [SEQ_IDX_W-1:0]          len;
      logic [MAX_SEQ-1:0][CODE_W-1:0] ch;
   } seq_type;

   function automatic char_type hex_char(logic [3:0] nib);
      char_type r;
      if (nib < 4'd10) begin
         r = CH_0 + {12'd0, nib};
      end else begin
         r = CH_A_UP + {12'd0, nib} - 16'd10;
      end
      return r;
   endfunction

   // Expand a job into its characters, first character at index 0
   function automatic seq_type build_seq(job_type j);
      seq_type s;
      logic [SEQ_IDX_W-1:0] n;
      logic [3:0][3:0] nib;
      s.ch = '0;
      s.len = '0;
      n = '0;
      if (j.lbf) begin
         nib = {j.code[7:4], j.code[3:0], j.code[15:12], j.code[11:8]};
      end else begin
         nib = {j.code[15:12], j.code[11:8], j.code[7:4], j.code[3:0]};
      end
      if (j.err) begin
         s.ch[0] = CH_NUL; n = 4'd1;
      end else begin
         if (j.pre_us) begin
            s.ch[n] = CH_US; n = n + 4'd1;
         end
         case (j.body)
            BODY_PLAIN: begin
               s.ch[n] = j.code; n = n + 4'd1;
            end
            BODY_DIGIT: begin
               s.ch[n] = CH_US; n = n + 4'd1;
               s.ch[n] = CH_H;  n = n + 4'd1;
               s.ch[n] = CH_0;  n = n + 4'd1;
               s.ch[n] = CH_1;  n = n + 4'd1;
               s.ch[n] = CH_US; n = n + 4'd1;
               s.ch[n] = j.code; n = n + 4'd1;
            end
            BODY_ESC_H: begin
               s.ch[n] = CH_US;   n = n + 4'd1;
               s.ch[n] = CH_H;    n = n + 4'd1;
               s.ch[n] = CH_5;    n = n + 4'd1;
               s.ch[n] = CH_F_UP; n = n + 4'd1;
               s.ch[n] = CH_US;   n = n + 4'd1;
            end
            BODY_ASCII: begin
               s.ch[n] = CH_US; n = n + 4'd1;
               s.ch[n] = CH_H;  n = n + 4'd1;
               s.ch[n] = hex_char(j.code[7:4]); n = n + 4'd1;
               s.ch[n] = hex_char(j.code[3:0]); n = n + 4'd1;
               s.ch[n] = CH_US; n = n + 4'd1;
            end
            BODY_WIDE_OPEN: begin
               s.ch[n] = CH_US; n = n + 4'd1;
               s.ch[n] = CH_H;  n = n + 4'd1;
               s.ch[n] = j.lbf ? CH_U_LO : CH_U_UP; n = n + 4'd1;
               s.ch[n] = hex_char(nib[3]); n = n + 4'd1;
               s.ch[n] = hex_char(nib[2]); n = n + 4'd1;
               s.ch[n] = hex_char(nib[1]); n = n + 4'd1;
               s.ch[n] = hex_char(nib[0]); n = n + 4'd1;
            end
            BODY_WIDE_CONT: begin
               s.ch[n] = hex_char(nib[3]); n = n + 4'd1;
               s.ch[n] = hex_char(nib[2]); n = n + 4'd1;
               s.ch[n] = hex_char(nib[1]); n = n + 4'd1;
               s.ch[n] = hex_char(nib[0]); n = n + 4'd1;
            end
            default: begin
               n = n;
            end
         endcase
         if (j.close_us) begin
            s.ch[n] = CH_US; n = n + 4'd1;
         end
      end
      s.len = n;
      return s;
   endfunction

endpackage

>>> hdl/iee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier escape encoder front end
// Accepts input words, tracks name state and classifies each word into a job
// for the expansion stage.
// ----------------------------------------------------------------------------
module iee_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  iee_pkg::char_type         req_code,
   input  logic                      req_last,
   input  logic                      encode_wide,
   input  logic                      low_byte_first,
   input  iee_pkg::queue_status_type q_status,
   output logic                      push,
   output iee_pkg::job_type          push_job
);

   logic at_start_ff, at_start_in;
   logic held_us_ff, held_us_in;
   logic run_open_ff, run_open_in;
   logic dropping_ff, dropping_in;
   logic accept;
   logic wide_unit;
   logic is_digit;
   logic is_alnum;
   iee_pkg::job_type job;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Classify the incoming word
   assign wide_unit = encode_wide && (req_code > iee_pkg::CH_ASCII_MAX);
   assign is_digit  = (req_code >= iee_pkg::CH_0) && (req_code <= iee_pkg::CH_9);
   assign is_alnum  = is_digit
                   || ((req_code >= iee_pkg::CH_A_UP) && (req_code <= iee_pkg::CH_Z_UP))
                   || ((req_code >= iee_pkg::CH_A_LO) && (req_code <= iee_pkg::CH_Z_LO));

   // Build the job and next name state
   always_comb begin
      logic done;
      done        = 1'b0;
      job         = '0;
      job.body    = iee_pkg::BODY_NONE;
      job.code    = req_code;
      job.last    = req_last;
      job.lbf     = low_byte_first;
      at_start_in = at_start_ff;
      held_us_in  = held_us_ff;
      run_open_in = run_open_ff;
      dropping_in = dropping_ff;
      if (dropping_ff) begin
         if (req_last) begin
            job.err     = 1'b1;
            at_start_in = 1'b1;
            dropping_in = 1'b0;
         end
      end else if (req_code == iee_pkg::CH_ILLEGAL) begin
         job.err     = 1'b1;
         held_us_in  = 1'b0;
         run_open_in = 1'b0;
         at_start_in = req_last;
         dropping_in = !req_last;
      end else begin
         if (held_us_ff) begin
            held_us_in = 1'b0;
            if (req_code == iee_pkg::CH_H) begin
               job.body = iee_pkg::BODY_ESC_H;
               done     = 1'b1;
            end else begin
               job.pre_us = 1'b1;
            end
         end else if (run_open_ff) begin
            if (wide_unit) begin
               job.body     = iee_pkg::BODY_WIDE_CONT;
               job.close_us = req_last;
               done         = 1'b1;
            end else begin
               job.pre_us  = 1'b1;
               run_open_in = 1'b0;
            end
         end
         if (!done) begin
            if (at_start_ff && is_digit) begin
               job.body = iee_pkg::BODY_DIGIT;
            end else if (req_code == iee_pkg::CH_US) begin
               if (req_last) begin
                  job.body = iee_pkg::BODY_PLAIN;
               end else begin
                  held_us_in = 1'b1;
               end
            end else if ((req_code <= iee_pkg::CH_ASCII_MAX) && !is_alnum) begin
               job.body = iee_pkg::BODY_ASCII;
            end else if (wide_unit) begin
               job.body     = iee_pkg::BODY_WIDE_OPEN;
               job.close_us = req_last;
               run_open_in  = !req_last;
            end else begin
               job.body = iee_pkg::BODY_PLAIN;
            end
         end
         at_start_in = 1'b0;
         if (req_last) begin
            at_start_in = 1'b1;
            held_us_in  = 1'b0;
            run_open_in = 1'b0;
            dropping_in = 1'b0;
         end
      end
   end

   // Push only words that produce output
   assign push     = accept && (job.err || job.pre_us || (job.body != iee_pkg::BODY_NONE));
   assign push_job = job;

   // Advance name state on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         held_us_ff  <= 1'b0;
         run_open_ff <= 1'b0;
         dropping_ff <= 1'b0;
      end else if (accept) begin
         at_start_ff <= at_start_in;
         held_us_ff  <= held_us_in;
         run_open_ff <= run_open_in;
         dropping_ff <= dropping_in;
      end
   end

endmodule

>>> hdl/iee_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier escape encoder job queue
// Short FIFO of classified jobs between the front end and the expander.
// ----------------------------------------------------------------------------
module iee_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  iee_pkg::job_type          push_job,
   input  logic                      pop,
   output iee_pkg::queue_status_type q_status,
   output iee_pkg::job_type          head_job
);

   iee_pkg::job_type entry_ff [iee_pkg::QUEUE_DEPTH];
   logic [iee_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [iee_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [iee_pkg::QPTR_W:0]   count_ff;
   logic [iee_pkg::QPTR_W:0]   count_in;

   assign q_status.full  = (count_ff == (iee_pkg::QPTR_W + 1)'(iee_pkg::QUEUE_DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign head_job       = entry_ff[rd_ptr_ff];

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Store jobs
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hdl/iee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Identifier escape encoder expander
// Walks the head job character by character into the output register.
// ----------------------------------------------------------------------------
module iee_back (
   input  logic                      clock,
   input  logic                      reset,
   input  iee_pkg::queue_status_type q_status,
   input  iee_pkg::job_type          head_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output iee_pkg::char_type         rsp_out_char,
   output logic                      rsp_run_last,
   output logic                      rsp_name_end,
   output logic                      rsp_error
);

   iee_pkg::seq_type seq;
   logic [iee_pkg::SEQ_IDX_W-1:0] idx_ff;
   logic load;
   logic final_char;
   logic rsp_valid_ff;
   iee_pkg::char_type out_char_ff;
   logic run_last_ff;
   logic name_end_ff;
   logic error_ff;

   assign seq        = iee_pkg::build_seq(head_job);
   assign load       = q_status.valid && (!rsp_valid_ff || !rsp_stall);
   assign final_char = (idx_ff == seq.len - 1'b1);
   assign pop        = load && final_char;

   // Step through the job
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff       <= final_char ? '0 : idx_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Load output word
   always_ff @(posedge clock) begin
      if (load) begin
         out_char_ff <= seq.ch[idx_ff];
         run_last_ff <= final_char;
         name_end_ff <= final_char && head_job.last;
         error_ff    <= head_job.err;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_name_end = name_end_ff;
   assign rsp_error    = error_ff;

endmodule

>>> hdl/identifier_escape_encoder_unit.sv
`timescale 1ns / 1ps
// A word passes a job queue entry before its first output is registered.
// Outputs go out one word per cycle unless rsp_stall holds them, so a plain
// character sustains one word a cycle; an N-output word emits them in turn.
// The four-entry job queue lets the front keep accepting while escapes drain.
// Reset (synchronous, active high) clears name state, queue and output valid;
// encode_wide resets to 0 and low_byte_first to 1.
// ----------------------------------------------------------------------------
// Identifier escape encoder
// Escapes a UTF-16 name into an identifier-safe stream, with an APB-style
// configuration port for wide-unit encoding.
// ----------------------------------------------------------------------------
module identifier_escape_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_char,
   output logic        rsp_run_last,
   output logic        rsp_name_end,
   output logic        rsp_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic encode_wide_ff;
   logic low_byte_first_ff;
   logic cfg_write;
   logic push;
   logic pop;
   iee_pkg::job_type          push_job;
   iee_pkg::job_type          head_job;
   iee_pkg::queue_status_type q_status;

   // Configuration registers
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         encode_wide_ff    <= 1'b0;
         low_byte_first_ff <= 1'b1;
      end else if (cfg_write) begin
         unique case (paddr[2])
            iee_pkg::REG_ENCODE_WIDE:    encode_wide_ff    <= pwdata[0];
            iee_pkg::REG_LOW_BYTE_FIRST: low_byte_first_ff <= pwdata[0];
            default:                     encode_wide_ff    <= encode_wide_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         iee_pkg::REG_ENCODE_WIDE:    prdata = {31'd0, encode_wide_ff};
         iee_pkg::REG_LOW_BYTE_FIRST: prdata = {31'd0, low_byte_first_ff};
         default:                     prdata = '0;
      endcase
   end

   iee_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code       (req_code),
      .req_last       (req_last),
      .encode_wide    (encode_wide_ff),
      .low_byte_first (low_byte_first_ff),
      .q_status       (q_status),
      .push           (push),
      .push_job       (push_job)
   );

   iee_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_status (q_status),
      .head_job (head_job)
   );

   iee_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last),
      .rsp_name_end (rsp_name_end),
      .rsp_error    (rsp_error)
   );

endmodule
